/* sv/ipbf_pkg.sv */
// Package for the IPv4 destination-port blocklist filter.
// Holds the protocol constants and the per-byte status struct shared by the modules.
// No dependencies.
package ipbf_pkg;

  localparam int unsigned PORT_W = 16;
  localparam int unsigned OFF_W = 7;
  localparam int unsigned HDR_W = 6;

  localparam logic [OFF_W-1:0] OFF_ETYPE_HI = 7'd12;
  localparam logic [OFF_W-1:0] OFF_ETYPE_LO = 7'd13;
  localparam logic [OFF_W-1:0] OFF_VER_IHL = 7'd14;
  localparam logic [OFF_W-1:0] OFF_FRAG_HI = 7'd20;
  localparam logic [OFF_W-1:0] OFF_FRAG_LO = 7'd21;
  localparam logic [OFF_W-1:0] OFF_PROTO = 7'd23;
  localparam logic [OFF_W-1:0] OFF_MAX = 7'd127;

  localparam logic [OFF_W-1:0] ETH_LEN = 7'd14;
  localparam logic [OFF_W-1:0] L4_START_MIN = 7'd34;
  localparam logic [HDR_W-1:0] IP_MIN_LEN = 6'd20;
  localparam logic [HDR_W-1:0] IP_MAX_LEN = 6'd60;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] FRAG_MASK = 16'h3fff;
  localparam logic [3:0] IP_VERSION = 4'd4;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] TCP_PORT_END = 8'd4;
  localparam logic [7:0] UDP_PORT_END = 8'd8;

  typedef struct packed {
    logic last;
    logic lookup;
    logic drop_ok;
  } byte_info_t;

endpackage

/* sv/ipbf_bitmap.sv */
// Blocklist bitmap: one bit per destination port, single write and single read port.
// Runs a clearing pass over every entry after reset. Depends on ipbf_pkg.
module ipbf_bitmap (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [ipbf_pkg::PORT_W-1:0]  wr_addr,
  input  logic                         wr_bit,
  input  logic                         rd_en,
  input  logic [ipbf_pkg::PORT_W-1:0]  rd_addr,
  output logic                         rd_bit,
  output logic                         busy
);

  localparam int unsigned DEPTH = 1 << ipbf_pkg::PORT_W;

  logic                        mem [0:DEPTH-1];
  logic [ipbf_pkg::PORT_W:0]   clr_count;
  logic                        mem_we;
  logic [ipbf_pkg::PORT_W-1:0] mem_addr;
  logic                        mem_bit;

  assign busy = !clr_count[ipbf_pkg::PORT_W];

  always_comb begin
    mem_we = wr_en;
    mem_addr = wr_addr;
    mem_bit = wr_bit;
    if (busy) begin
      mem_we = 1'b1;
      mem_addr = clr_count[ipbf_pkg::PORT_W-1:0];
      mem_bit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_count <= '0;
    end else if (busy) begin
      clr_count <= clr_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_bit;
    end
    if (rd_en) begin
      rd_bit <= mem[rd_addr];
    end
  end

endmodule

/* sv/ipbf_parser.sv */
// Frame parser: tracks the byte offset and the Ethernet and IPv4 header checks.
// Produces the port lookup address and a status struct per byte. Depends on ipbf_pkg.
module ipbf_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  output logic [ipbf_pkg::PORT_W-1:0] lookup_addr,
  output ipbf_pkg::byte_info_t        info
);

  logic [ipbf_pkg::OFF_W-1:0] byte_offset;
  logic [7:0]                 ether_high;
  logic [ipbf_pkg::HDR_W-1:0] header_bytes;
  logic [7:0]                 ip_protocol;
  logic                       header_checks_ok;
  logic [7:0]                 port_high;

  logic [ipbf_pkg::OFF_W-1:0] byte_offset_next;
  logic [7:0]                 ether_high_next;
  logic [ipbf_pkg::HDR_W-1:0] header_bytes_next;
  logic [7:0]                 ip_protocol_next;
  logic                       header_checks_ok_next;
  logic [7:0]                 port_high_next;

  logic [ipbf_pkg::OFF_W-1:0] l4_start;
  logic [7:0]                 off8;
  logic [7:0]                 len8;
  logic [7:0]                 l4_8;
  logic [ipbf_pkg::HDR_W-1:0] ihl4;
  logic                       in_l4;
  logic                       len_ok;

  assign l4_start = ipbf_pkg::ETH_LEN + {1'b0, header_bytes};
  assign off8 = {1'b0, byte_offset};
  assign len8 = off8 + 8'd1;
  assign l4_8 = {1'b0, l4_start};
  assign ihl4 = {data_byte[3:0], 2'b00};
  assign in_l4 = byte_offset >= ipbf_pkg::L4_START_MIN;
  assign lookup_addr = {port_high, data_byte};

  always_comb begin
    ether_high_next = ether_high;
    header_bytes_next = header_bytes;
    ip_protocol_next = ip_protocol;
    header_checks_ok_next = header_checks_ok;
    port_high_next = port_high;
    info.lookup = 1'b0;
    info.last = last_byte;

    case (byte_offset)
      ipbf_pkg::OFF_ETYPE_HI: begin
        ether_high_next = data_byte;
      end
      ipbf_pkg::OFF_ETYPE_LO: begin
        if ({ether_high, data_byte} != ipbf_pkg::ETHERTYPE_IPV4) begin
          header_checks_ok_next = 1'b0;
        end
      end
      ipbf_pkg::OFF_VER_IHL: begin
        if (data_byte[7:4] != ipbf_pkg::IP_VERSION || ihl4 < ipbf_pkg::IP_MIN_LEN ||
            ihl4 > ipbf_pkg::IP_MAX_LEN) begin
          header_checks_ok_next = 1'b0;
        end
        header_bytes_next = ihl4;
      end
      ipbf_pkg::OFF_FRAG_HI: begin
        if ((data_byte & ipbf_pkg::FRAG_MASK[15:8]) != 8'd0) begin
          header_checks_ok_next = 1'b0;
        end
      end
      ipbf_pkg::OFF_FRAG_LO: begin
        if ((data_byte & ipbf_pkg::FRAG_MASK[7:0]) != 8'd0) begin
          header_checks_ok_next = 1'b0;
        end
      end
      ipbf_pkg::OFF_PROTO: begin
        ip_protocol_next = data_byte;
      end
      default: begin
      end
    endcase

    if (in_l4) begin
      if (off8 == l4_8 + 8'd2) begin
        port_high_next = data_byte;
      end else if (off8 == l4_8 + 8'd3) begin
        info.lookup = 1'b1;
      end
    end

    len_ok = header_checks_ok_next && len8 >= {1'b0, ipbf_pkg::L4_START_MIN} && len8 >= l4_8;
    if (ip_protocol_next == ipbf_pkg::PROTO_TCP) begin
      info.drop_ok = len_ok && len8 >= l4_8 + ipbf_pkg::TCP_PORT_END;
    end else if (ip_protocol_next == ipbf_pkg::PROTO_UDP) begin
      info.drop_ok = len_ok && len8 >= l4_8 + ipbf_pkg::UDP_PORT_END;
    end else begin
      info.drop_ok = 1'b0;
    end

    if (byte_offset < ipbf_pkg::OFF_MAX) begin
      byte_offset_next = byte_offset + 1'b1;
    end else begin
      byte_offset_next = byte_offset;
    end

    if (last_byte) begin
      byte_offset_next = '0;
      ether_high_next = '0;
      header_bytes_next = '0;
      ip_protocol_next = '0;
      header_checks_ok_next = 1'b1;
      port_high_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      ether_high <= '0;
      header_bytes <= '0;
      ip_protocol <= '0;
      header_checks_ok <= 1'b1;
      port_high <= '0;
    end else if (fire) begin
      byte_offset <= byte_offset_next;
      ether_high <= ether_high_next;
      header_bytes <= header_bytes_next;
      ip_protocol <= ip_protocol_next;
      header_checks_ok <= header_checks_ok_next;
      port_high <= port_high_next;
    end
  end

endmodule

/* sv/ipv4_port_block_filter_core.sv */
// The block accepts one transfer per cycle, frame bytes and blocklist writes alike, while
// in_ready is high, and gives one drop or pass verdict per frame after its last byte is
// accepted, through the input register, the registered blocklist read and the output
// register. After reset the blocklist memory is cleared one port per cycle, and in_ready
// stays low until that pass is done.
// Top level of the filter; depends on ipbf_pkg, ipbf_parser and ipbf_bitmap.
module ipv4_port_block_filter_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  input  logic [ipbf_pkg::PORT_W-1:0] port,
  input  logic                        block_flag,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        verdict
);

  logic                        s1_valid;
  logic                        s1_req;
  logic [7:0]                  s1_data;
  logic                        s1_last;
  logic [ipbf_pkg::PORT_W-1:0] s1_port;
  logic                        s1_flag;
  logic                        s1_adv;
  logic                        frame_fire;
  logic                        table_wr;

  logic                        s2_valid;
  ipbf_pkg::byte_info_t        s2_info;
  logic                        s2_adv;
  logic                        s2_hit;
  logic                        port_hit;

  ipbf_pkg::byte_info_t        s1_info;
  logic [ipbf_pkg::PORT_W-1:0] lookup_addr;
  logic                        rd_bit;
  logic                        busy;

  assign s2_adv = s2_valid && (!s2_info.last || !out_valid || out_ready);
  assign s1_adv = s1_valid && (s1_req || !s2_valid || s2_adv);
  assign in_ready = !busy && (!s1_valid || s1_adv);
  assign frame_fire = s1_adv && !s1_req;
  assign table_wr = s1_adv && s1_req;
  assign s2_hit = s2_info.lookup ? rd_bit : port_hit;

  ipbf_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (frame_fire),
    .data_byte   (s1_data),
    .last_byte   (s1_last),
    .lookup_addr (lookup_addr),
    .info        (s1_info)
  );

  ipbf_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (table_wr),
    .wr_addr (s1_port),
    .wr_bit  (s1_flag),
    .rd_en   (frame_fire),
    .rd_addr (lookup_addr),
    .rd_bit  (rd_bit),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req <= req_type;
      s1_data <= data_byte;
      s1_last <= last_byte;
      s1_port <= port;
      s1_flag <= block_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (frame_fire) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_fire) begin
      s2_info <= s1_info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_hit <= 1'b0;
    end else if (s2_adv) begin
      if (s2_info.last) begin
        port_hit <= 1'b0;
      end else if (s2_info.lookup) begin
        port_hit <= rd_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv && s2_info.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_info.last) begin
      verdict <= s2_info.drop_ok && s2_hit;
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> !in_ready)
    else $error("Transfer accepted during the blocklist clearing pass.");

  assert property (@(posedge clk) disable iff (rst) s1_valid |-> !busy)
    else $error("Input register holds an item during the clearing pass.");

  assert property (@(posedge clk) disable iff (rst) (s2_adv && s2_info.last) |=> out_valid)
    else $error("Frame end left the lookup stage without a verdict.");

endmodule

/* sim/tb_ipv4_port_block_filter_core.sv */
// Testbench for ipv4_port_block_filter_core: drives frame bytes and blocklist writes,
// predicts the per-frame drop verdict and checks every verdict in order.
// Depends on ipbf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_ipv4_port_block_filter_core;

  localparam bit REQ_FRAME = 1'b0;
  localparam bit REQ_WRITE = 1'b1;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [15:0] FRAG_DF = 16'h4000;
  localparam logic [15:0] FRAG_MF = 16'h2000;

  class verdict_scoreboard;
    bit       blocked [0:65535];
    bit [6:0] offset;
    bit [7:0] etype_hi;
    bit [5:0] hdr_len;
    bit [7:0] proto;
    bit       hdr_ok;
    bit [7:0] dport_hi;
    bit       dport_hit;
    bit       expected_q [$];
    int       mismatches;

    function new();
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      offset = 0;
      etype_hi = 0;
      hdr_len = 0;
      proto = 0;
      hdr_ok = 1'b1;
      dport_hi = 0;
      dport_hit = 1'b0;
    endfunction

    function void note_item(bit rq, bit [7:0] d, bit lst, bit [15:0] p, bit bf);
      int off;
      int l4;
      int ihl4;
      bit drop;
      off = offset;
      l4 = int'(ipbf_pkg::ETH_LEN) + int'(hdr_len);
      if (rq == REQ_WRITE) begin
        blocked[p] = bf;
        return;
      end
      if (off == ipbf_pkg::OFF_ETYPE_HI) begin
        etype_hi = d;
      end else if (off == ipbf_pkg::OFF_ETYPE_LO) begin
        if ({etype_hi, d} != ipbf_pkg::ETHERTYPE_IPV4) hdr_ok = 1'b0;
      end else if (off == ipbf_pkg::OFF_VER_IHL) begin
        ihl4 = int'(d[3:0]) * 4;
        if (d[7:4] != ipbf_pkg::IP_VERSION || ihl4 < int'(ipbf_pkg::IP_MIN_LEN) ||
            ihl4 > int'(ipbf_pkg::IP_MAX_LEN))
          hdr_ok = 1'b0;
        hdr_len = ihl4[5:0];
      end else if (off == ipbf_pkg::OFF_FRAG_HI) begin
        if ((d & ipbf_pkg::FRAG_MASK[15:8]) != 0) hdr_ok = 1'b0;
      end else if (off == ipbf_pkg::OFF_FRAG_LO) begin
        if ((d & ipbf_pkg::FRAG_MASK[7:0]) != 0) hdr_ok = 1'b0;
      end else if (off == ipbf_pkg::OFF_PROTO) begin
        proto = d;
      end
      if (off >= int'(ipbf_pkg::L4_START_MIN)) begin
        if (off == l4 + 2) dport_hi = d;
        else if (off == l4 + 3) dport_hit = blocked[{dport_hi, d}];
      end
      if (lst) begin
        drop = hdr_ok && dport_hit && off + 1 >= int'(ipbf_pkg::L4_START_MIN) &&
               off + 1 >= l4;
        if (proto == ipbf_pkg::PROTO_TCP)
          drop = drop && off + 1 >= l4 + int'(ipbf_pkg::TCP_PORT_END);
        else if (proto == ipbf_pkg::PROTO_UDP)
          drop = drop && off + 1 >= l4 + int'(ipbf_pkg::UDP_PORT_END);
        else drop = 1'b0;
        expected_q.push_back(drop);
        clear_frame();
      end else if (off < int'(ipbf_pkg::OFF_MAX)) begin
        offset = offset + 7'd1;
      end
    endfunction

    function void check_verdict(logic v);
      bit want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected verdict %b with no frame outstanding.", v);
      end else begin
        want = expected_q.pop_front();
        if (v !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Verdict mismatch: expected %b, got %b.", want, v);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] port;
  logic        block_flag;
  logic        out_valid;
  logic        out_ready;
  logic        verdict;

  verdict_scoreboard sb = new();

  bit [7:0]  frame_bytes [$];
  bit [15:0] port_pool [8];
  int        items_sent = 0;
  int        frames_sent = 0;
  bit        tx_steady = 1'b0;
  bit        long_hold = 1'b0;

  ipv4_port_block_filter_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .port(port),
    .block_flag(block_flag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .verdict(verdict)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAIL ipv4_port_block_filter_core");
    $finish;
  end

  task automatic send_item(bit rq, bit [7:0] d, bit lst, bit [15:0] p, bit bf);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    data_byte <= d;
    last_byte <= lst;
    port <= p;
    block_flag <= bf;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_item(rq, d, lst, p, bf);
    items_sent++;
  endtask

  task automatic send_write(bit [15:0] p, bit bf);
    send_item(REQ_WRITE, 8'($urandom), 1'($urandom), p, bf);
  endtask

  task automatic send_frame(int wr_at, bit [15:0] wr_port, bit wr_flag);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (i == wr_at) send_write(wr_port, wr_flag);
      send_item(REQ_FRAME, frame_bytes[i], i == frame_bytes.size() - 1, 16'($urandom),
                1'($urandom));
    end
    frames_sent++;
  endtask

  task automatic build_frame(bit [15:0] etype, bit [7:0] ver_ihl, bit [15:0] frag,
                             bit [7:0] prot, bit [15:0] dport, int len);
    int l4;
    bit [7:0] b;
    l4 = int'(ipbf_pkg::ETH_LEN) + int'(ver_ihl[3:0]) * 4;
    frame_bytes.delete();
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == l4 + 2) b = dport[15:8];
      else if (i == l4 + 3) b = dport[7:0];
      if (i == ipbf_pkg::OFF_ETYPE_HI) b = etype[15:8];
      else if (i == ipbf_pkg::OFF_ETYPE_LO) b = etype[7:0];
      else if (i == ipbf_pkg::OFF_VER_IHL) b = ver_ihl;
      else if (i == ipbf_pkg::OFF_FRAG_HI) b = frag[15:8];
      else if (i == ipbf_pkg::OFF_FRAG_LO) b = frag[7:0];
      else if (i == ipbf_pkg::OFF_PROTO) b = prot;
      frame_bytes.push_back(b);
    end
  endtask

  task automatic directed_frame(bit [15:0] etype, bit [7:0] ver_ihl, bit [15:0] frag,
                                bit [7:0] prot, bit [15:0] dport, int len);
    build_frame(etype, ver_ihl, frag, prot, dport, len);
    send_frame(-1, 16'h0000, 1'b0);
  endtask

  task automatic random_frame();
    int ihl;
    int len;
    int need;
    int wr_at;
    bit tcp;
    bit [3:0] ver;
    bit [7:0] prot;
    bit [15:0] etype;
    bit [15:0] frag;
    bit [15:0] dport;
    if ($urandom_range(0, 9) < 3) begin
      build_frame(16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                  $urandom_range(1, 40));
    end else begin
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
      tcp = 1'($urandom_range(0, 1));
      prot = tcp ? ipbf_pkg::PROTO_TCP : ipbf_pkg::PROTO_UDP;
      need = int'(ipbf_pkg::ETH_LEN) + ihl * 4 +
             (tcp ? int'(ipbf_pkg::TCP_PORT_END) : int'(ipbf_pkg::UDP_PORT_END));
      len = need + $urandom_range(0, 6);
      if ($urandom_range(0, 39) == 0) len = $urandom_range(128, 160);
      etype = ipbf_pkg::ETHERTYPE_IPV4;
      ver = ipbf_pkg::IP_VERSION;
      frag = 16'($urandom_range(0, 3)) << 14;
      dport = ($urandom_range(0, 4) != 0) ? port_pool[$urandom_range(0, 7)] : 16'($urandom);
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 5))
          0: etype = etype ^ (16'(1) << $urandom_range(0, 15));
          1: ver = ipbf_pkg::IP_VERSION ^ 4'($urandom_range(1, 15));
          2: ihl = $urandom_range(0, 4);
          3: frag = frag | (16'(1) << $urandom_range(0, 13));
          4: prot = 8'($urandom);
          default: len = $urandom_range(1, need - 1);
        endcase
      end
      build_frame(etype, {ver, 4'(ihl)}, frag, prot, dport, len);
    end
    wr_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, frame_bytes.size() - 1) : -1;
    send_frame(wr_at, port_pool[$urandom_range(0, 7)], $urandom_range(0, 3) != 0);
  endtask

  task automatic random_traffic(int item_goal, int frame_goal);
    while (items_sent < item_goal || frames_sent < frame_goal) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) port_pool[$urandom_range(2, 7)] = 16'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 3) == 0) send_write(16'($urandom), 1'($urandom));
        else send_write(port_pool[$urandom_range(0, 7)], $urandom_range(0, 3) != 0);
      end
      random_frame();
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= REQ_FRAME;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    port <= 16'h0000;
    block_flag <= 1'b0;
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hffff;
    for (int i = 2; i < 8; i++) port_pool[i] = 16'($urandom);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_write(port_pool[0], 1'b1);
    send_write(port_pool[1], 1'b1);
    send_write(port_pool[2], 1'b1);
    send_write(port_pool[3], 1'b0);
    directed_frame(ipbf_pkg::ETHERTYPE_IPV4, {ipbf_pkg::IP_VERSION, 4'd5}, 16'h0000,
                   ipbf_pkg::PROTO_TCP, port_pool[0], 38);
    directed_frame(ipbf_pkg::ETHERTYPE_IPV4, {ipbf_pkg::IP_VERSION, 4'd15}, 16'h0000,
                   ipbf_pkg::PROTO_UDP, port_pool[1], 82);
    directed_frame(ipbf_pkg::ETHERTYPE_IPV4, {ipbf_pkg::IP_VERSION, 4'd5}, 16'h0000,
                   ipbf_pkg::PROTO_TCP, port_pool[1], 37);
    directed_frame(ipbf_pkg::ETHERTYPE_IPV4, {ipbf_pkg::IP_VERSION, 4'd5}, 16'h0000,
                   ipbf_pkg::PROTO_UDP, port_pool[3], 42);
    directed_frame(ipbf_pkg::ETHERTYPE_IPV4, {ipbf_pkg::IP_VERSION, 4'd5}, FRAG_DF,
                   ipbf_pkg::PROTO_TCP, port_pool[0], 38);
    directed_frame(ipbf_pkg::ETHERTYPE_IPV4, {ipbf_pkg::IP_VERSION, 4'd5}, 16'h0001,
                   ipbf_pkg::PROTO_TCP, port_pool[0], 38);
    directed_frame(ipbf_pkg::ETHERTYPE_IPV4, {ipbf_pkg::IP_VERSION, 4'd5}, FRAG_MF,
                   ipbf_pkg::PROTO_TCP, port_pool[0], 38);
    directed_frame(16'h86dd, {ipbf_pkg::IP_VERSION, 4'd5}, 16'h0000,
                   ipbf_pkg::PROTO_TCP, port_pool[0], 38);
    directed_frame(ipbf_pkg::ETHERTYPE_IPV4, {4'd6, 4'd5}, 16'h0000,
                   ipbf_pkg::PROTO_TCP, port_pool[0], 38);
    directed_frame(ipbf_pkg::ETHERTYPE_IPV4, {ipbf_pkg::IP_VERSION, 4'd4}, 16'h0000,
                   ipbf_pkg::PROTO_TCP, port_pool[0], 38);
    directed_frame(ipbf_pkg::ETHERTYPE_IPV4, {ipbf_pkg::IP_VERSION, 4'd5}, 16'h0000,
                   PROTO_ICMP, port_pool[0], 42);
    directed_frame(ipbf_pkg::ETHERTYPE_IPV4, {ipbf_pkg::IP_VERSION, 4'd5}, 16'h0000,
                   ipbf_pkg::PROTO_TCP, port_pool[0], 150);

    // An unblock after the lookup byte must not change this frame, one before it must.
    build_frame(ipbf_pkg::ETHERTYPE_IPV4, {ipbf_pkg::IP_VERSION, 4'd5}, 16'h0000,
                ipbf_pkg::PROTO_TCP, port_pool[2], 40);
    send_frame(38, port_pool[2], 1'b0);
    send_write(port_pool[2], 1'b1);
    build_frame(ipbf_pkg::ETHERTYPE_IPV4, {ipbf_pkg::IP_VERSION, 4'd5}, 16'h0000,
                ipbf_pkg::PROTO_TCP, port_pool[0], 40);
    send_frame(10, port_pool[0], 1'b0);
    send_write(port_pool[0], 1'b1);

    frame_bytes = '{8'h00};
    send_frame(-1, 16'h0000, 1'b0);
    frame_bytes = '{8'hff};
    send_frame(-1, 16'h0000, 1'b0);

    random_traffic(400, 0);

    // Back-to-back tiny frames while the receiver holds off fill the pipeline.
    long_hold = 1'b1;
    tx_steady = 1'b1;
    repeat (40) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 2)) frame_bytes.push_back(8'($urandom));
      send_frame(-1, 16'h0000, 1'b0);
    end

    random_traffic(850, 0);

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS ipv4_port_block_filter_core");
    end else begin
      $display("FAIL ipv4_port_block_filter_core");
    end
    $finish;
  end

  initial begin
    int gap;
    bit rx_steady;
    rx_steady = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 3);
      if (long_hold) begin
        gap = 200;
        long_hold = 1'b0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_verdict(verdict);
    end
  end

endmodule

/* filelist.f */
sv/ipbf_pkg.sv
sv/ipbf_bitmap.sv
sv/ipbf_parser.sv
sv/ipv4_port_block_filter_core.sv
sim/tb_ipv4_port_block_filter_core.sv
